>>> rtl/tcpwm_pkg.sv
package tcpwm_pkg;

    // Block shape
    localparam int CHANNELS   = 3;
    localparam int TIME_WIDTH = 32;
    localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LEVEL_BITS = 3;
    localparam int OUT_CH     = (CHANNELS < LEVEL_BITS) ? CHANNELS : LEVEL_BITS;

    // Word fields
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Register map
    localparam logic [ADDR_W-1:0] CTRL_BASE = 6'h18;

    // Control word bits
    localparam int CTRL_RUN_BIT     = 0;
    localparam int CTRL_RESTART_BIT = 1;

    // Per-channel operation for one step
    typedef struct packed {
        logic tick;
        logic wr_high;
        logic wr_low;
        logic wr_ctrl;
    } chan_op_t;

endpackage

>>> rtl/tcpwm_channel.sv
module tcpwm_channel
    import tcpwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chan_op_t              op,
    input  logic [DATA_W-1:0]     wdata,
    output logic [TIME_WIDTH-1:0] high_time,
    output logic [TIME_WIDTH-1:0] low_time,
    output logic [DATA_W-1:0]     control_word,
    output logic                  level
);

    logic [TIME_WIDTH-1:0] high_reg;
    logic [TIME_WIDTH-1:0] high_next;
    logic [TIME_WIDTH-1:0] low_reg;
    logic [TIME_WIDTH-1:0] low_next;
    logic [DATA_W-1:0]     ctrl_reg;
    logic [DATA_W-1:0]     ctrl_next;
    logic [TIME_WIDTH:0]   count_reg;
    logic [TIME_WIDTH:0]   count_next;
    logic [TIME_WIDTH:0]   period;
    logic [TIME_WIDTH+1:0] count_inc;
    logic                  wrap;
    logic                  clear_count;

    // Period and wrap test for a tick
    assign period    = {1'b0, high_reg} + {1'b0, low_reg};
    assign count_inc = {1'b0, count_reg} + {{(TIME_WIDTH+1){1'b0}}, 1'b1};
    assign wrap      = count_inc >= {1'b0, period};

    // Restart or stop puts the count back to the start of the high phase
    assign clear_count = op.wr_ctrl && (wdata[CTRL_RESTART_BIT] || !wdata[CTRL_RUN_BIT]);

    // Next state
    always_comb
    begin
        high_next  = op.wr_high ? wdata[TIME_WIDTH-1:0] : high_reg;
        low_next   = op.wr_low  ? wdata[TIME_WIDTH-1:0] : low_reg;
        ctrl_next  = ctrl_reg;
        if (op.wr_ctrl)
        begin
            ctrl_next                   = wdata;
            ctrl_next[CTRL_RESTART_BIT] = 1'b0;
        end
        count_next = count_reg;
        if (clear_count)
        begin
            count_next = '0;
        end
        else if (op.tick && ctrl_reg[CTRL_RUN_BIT])
        begin
            count_next = wrap ? '0 : count_inc[TIME_WIDTH:0];
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg  <= '0;
            low_reg   <= '0;
            ctrl_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            high_reg  <= high_next;
            low_reg   <= low_next;
            ctrl_reg  <= ctrl_next;
            count_reg <= count_next;
        end
    end

    // Level after this step
    assign level = ctrl_next[CTRL_RUN_BIT] && (count_next < {1'b0, high_next});

    assign high_time    = high_reg;
    assign low_time     = low_reg;
    assign control_word = ctrl_reg;

endmodule

>>> rtl/three_channel_pwm_generator.sv
// Three-channel PWM generator with separate high and low times.
//
// Input channel (in_valid/in_ready) takes one word per cycle unless stalled:
// a register read, a register write, or one reference tick that advances every
// running channel. Output channel (out_valid/out_ready) returns one word for
// each input word, in order: read_data holds the register value for a read
// and zero otherwise; pwm_levels holds each channel's level after the step.
//
// A word accepted into the input register moves on into the result register,
// where its result is shown, unless the receiver stalls. Throughput: one word
// per cycle while not stalled, set by the state update of each channel between
// the input register and the result register.
//
// Reset clears all times, control words and phase counts; every channel is
// stopped and drives low. When the receiver stalls, the result register
// holds, the input register fills behind it, and in_ready drops until the
// result is taken.
module three_channel_pwm_generator
    import tcpwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     read_data,
    output logic [LEVEL_BITS-1:0] pwm_levels
);

    logic                  in_valid_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     read_data_reg;
    logic [LEVEL_BITS-1:0] levels_reg;
    logic                  advance;

    logic                  time_hit;
    logic                  ctrl_hit;
    logic [CHAN_W-1:0]     time_chan;
    logic [ADDR_W-1:0]     ctrl_off;
    logic [ADDR_W-3:0]     ctrl_slot;
    logic [CHAN_W-1:0]     ctrl_chan;
    logic [DATA_W-1:0]     rd_value;
    logic [LEVEL_BITS-1:0] levels_value;

    logic [TIME_WIDTH-1:0] high_time [CHANNELS];
    logic [TIME_WIDTH-1:0] low_time [CHANNELS];
    logic [DATA_W-1:0]     control_word [CHANNELS];
    logic [CHANNELS-1:0]   level;
    chan_op_t              op [CHANNELS];

    // Move a word forward when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Hold the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
    end

    // Decode the register address; time registers win over control words
    assign time_hit  = (addr_reg[1:0] == 2'b00) &&
                       ({3'b000, addr_reg[ADDR_W-1:3]} < ADDR_W'(CHANNELS));
    assign time_chan = addr_reg[3+CHAN_W-1:3];
    assign ctrl_off  = addr_reg - CTRL_BASE;
    assign ctrl_slot = ctrl_off[ADDR_W-1:2];
    assign ctrl_hit  = (addr_reg[1:0] == 2'b00) && !time_hit && (addr_reg >= CTRL_BASE) &&
                       (ctrl_slot < (ADDR_W-2)'(CHANNELS));
    assign ctrl_chan = ctrl_slot[CHAN_W-1:0];

    // Drive one operation per channel
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        always_comb
        begin
            op[i].tick    = advance && (cmd_reg == CMD_TICK);
            op[i].wr_high = advance && (cmd_reg == CMD_WRITE) && time_hit &&
                            (time_chan == CHAN_W'(i)) && !addr_reg[2];
            op[i].wr_low  = advance && (cmd_reg == CMD_WRITE) && time_hit &&
                            (time_chan == CHAN_W'(i)) && addr_reg[2];
            op[i].wr_ctrl = advance && (cmd_reg == CMD_WRITE) && ctrl_hit &&
                            (ctrl_chan == CHAN_W'(i));
        end

        tcpwm_channel u_channel (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (op[i]),
            .wdata        (wdata_reg),
            .high_time    (high_time[i]),
            .low_time     (low_time[i]),
            .control_word (control_word[i]),
            .level        (level[i])
        );
    end

    // Select read data from the state before the step
    always_comb
    begin
        rd_value = '0;
        if (cmd_reg == CMD_READ)
        begin
            if (time_hit)
            begin
                rd_value = addr_reg[2] ? DATA_W'(low_time[time_chan])
                                       : DATA_W'(high_time[time_chan]);
            end
            else if (ctrl_hit)
            begin
                rd_value = control_word[ctrl_chan];
            end
        end
    end

    // Drop channels past the level field
    always_comb
    begin
        levels_value = '0;
        for (int i = 0; i < OUT_CH; i++)
        begin
            levels_value[i] = level[i];
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= rd_value;
            levels_reg    <= levels_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign pwm_levels = levels_reg;

endmodule

>>> rtl/tcpwm_checker.sv
module tcpwm_checker
    import tcpwm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [CMD_W-1:0]      command,
    input logic [ADDR_W-1:0]     address,
    input logic [DATA_W-1:0]     write_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_W-1:0]     read_data,
    input logic [LEVEL_BITS-1:0] pwm_levels
);

    // A stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(pwm_levels))
        else $error("result word changed while stalled");

    // A waiting input word holds its value
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(command) && $stable(address) &&
        $stable(write_data))
        else $error("input word changed while waiting");

    // No result comes out in the first cycle after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result word shown right after reset");

    // An idle output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Every accepted word is followed by a valid result word on the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("result word missing two cycles after accept");

endmodule

bind three_channel_pwm_generator tcpwm_checker u_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

import tcpwm_pkg::*;

// Command code outside the defined set; the block must treat it as a no-op
localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

typedef enum logic [1:0] {REG_NONE, REG_HIGH, REG_LOW, REG_CTRL} pwm_reg_kind_t;

typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic [LEVEL_BITS-1:0] pwm_levels;
} pwm_result_t;

// Mirror of the register file and phase counters, plus the results still owed
class pwm_mirror;
    logic [TIME_WIDTH-1:0] high_time [CHANNELS];
    logic [TIME_WIDTH-1:0] low_time  [CHANNELS];
    logic [DATA_W-1:0]     ctrl_word [CHANNELS];
    logic [TIME_WIDTH:0]   phase     [CHANNELS];
    pwm_result_t           owed_results [$];
    int                    mismatches;

    function new();
        for (int c = 0; c < CHANNELS; c++)
        begin
            high_time[c] = '0;
            low_time[c]  = '0;
            ctrl_word[c] = '0;
            phase[c]     = '0;
        end
        mismatches = 0;
    endfunction

    // Advance every running channel by one reference tick
    function void advance_phases();
        logic [63:0] period;
        for (int c = 0; c < CHANNELS; c++)
        begin
            period = 64'(high_time[c]) + 64'(low_time[c]);
            if (ctrl_word[c][CTRL_RUN_BIT])
            begin
                if (64'(phase[c]) + 64'd1 >= period)
                    phase[c] = '0;
                else
                    phase[c] = phase[c] + 1'b1;
            end
        end
    endfunction

    // Note one accepted word: update the mirror and queue its result
    function void log_word(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
        pwm_reg_kind_t kind;
        int            chan;
        pwm_result_t   res;
        kind = REG_NONE;
        chan = 0;
        res  = '0;
        // decode the byte offset
        if (addr[1:0] == 2'b00)
        begin
            if (int'(addr >> 3) < CHANNELS)
            begin
                chan = int'(addr >> 3);
                kind = addr[2] ? REG_LOW : REG_HIGH;
            end
            else if (addr >= CTRL_BASE && int'((addr - CTRL_BASE) >> 2) < CHANNELS)
            begin
                chan = int'((addr - CTRL_BASE) >> 2);
                kind = REG_CTRL;
            end
        end
        if (cmd == CMD_TICK)
            advance_phases();
        else if (cmd == CMD_READ)
        begin
            case (kind)
                REG_HIGH: res.read_data = DATA_W'(high_time[chan]);
                REG_LOW:  res.read_data = DATA_W'(low_time[chan]);
                REG_CTRL: res.read_data = ctrl_word[chan];
                default:  res.read_data = '0;
            endcase
        end
        else if (cmd == CMD_WRITE)
        begin
            case (kind)
                REG_HIGH: high_time[chan] = data[TIME_WIDTH-1:0];
                REG_LOW:  low_time[chan]  = data[TIME_WIDTH-1:0];
                REG_CTRL:
                begin
                    ctrl_word[chan] = data;
                    ctrl_word[chan][CTRL_RESTART_BIT] = 1'b0;
                    if (data[CTRL_RESTART_BIT] || !data[CTRL_RUN_BIT])
                        phase[chan] = '0;
                end
                default: ;
            endcase
        end
        // levels after the step
        for (int c = 0; c < OUT_CH; c++)
            res.pwm_levels[c] = ctrl_word[c][CTRL_RUN_BIT] &&
                                (64'(phase[c]) < 64'(high_time[c]));
        owed_results.push_back(res);
    endfunction

    // Compare one accepted result against the oldest one owed
    function void match_result(logic [DATA_W-1:0] rd, logic [LEVEL_BITS-1:0] lv);
        pwm_result_t exp_res;
        if (owed_results.size() == 0)
        begin
            $error("unexpected result: read_data %h pwm_levels %b", rd, lv);
            mismatches++;
            return;
        end
        exp_res = owed_results.pop_front();
        if (rd !== exp_res.read_data)
        begin
            $error("read_data: expected %h, actual %h", exp_res.read_data, rd);
            mismatches++;
        end
        if (lv !== exp_res.pwm_levels)
        begin
            $error("pwm_levels: expected %b, actual %b", exp_res.pwm_levels, lv);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_WORDS = 700;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = CMD_READ;
    logic [ADDR_W-1:0]     address = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic [LEVEL_BITS-1:0] pwm_levels;

    pwm_mirror mirror = new();
    bit        calm = 1'b0;
    int        quiet_cycles = 0;

    three_channel_pwm_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .pwm_levels (pwm_levels)
    );

    always #5 clk = ~clk;

    function automatic logic [ADDR_W-1:0] high_addr(int c);
        return ADDR_W'(c * 8);
    endfunction

    function automatic logic [ADDR_W-1:0] low_addr(int c);
        return ADDR_W'(c * 8 + 4);
    endfunction

    function automatic logic [ADDR_W-1:0] ctrl_addr(int c);
        return CTRL_BASE + ADDR_W'(c * 4);
    endfunction

    // Offer one word, idling at random first, and hold it until taken
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        address    <= addr;
        write_data <= data;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.log_word(cmd, addr, data);
    endtask

    // Drain results with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                mirror.match_result(read_data, pwm_levels);
            out_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int               roll;
        int               pick;
        int               chan;
        logic [DATA_W-1:0] value;
        logic [ADDR_W-1:0] where;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: restart bit, readback, ticks on a short period
        send_word(CMD_READ,  ctrl_addr(0), 32'h0);
        send_word(CMD_WRITE, high_addr(0), 32'd2);
        send_word(CMD_WRITE, low_addr(0),  32'd3);
        send_word(CMD_WRITE, ctrl_addr(0), 32'h4003);
        send_word(CMD_READ,  ctrl_addr(0), 32'h0);
        send_word(CMD_TICK,  6'h3F,        32'hFFFF_FFFF);
        send_word(CMD_TICK,  6'h00,        32'h0);
        // maximum times on channel 1, all control bits
        send_word(CMD_WRITE, high_addr(1), 32'hFFFF_FFFF);
        send_word(CMD_WRITE, low_addr(1),  32'hFFFF_FFFF);
        send_word(CMD_WRITE, ctrl_addr(1), 32'hFFFF_FFFF);
        send_word(CMD_READ,  ctrl_addr(1), 32'h0);
        // shrink the period under a running count
        send_word(CMD_TICK,  6'h00,        32'h0);
        send_word(CMD_WRITE, high_addr(0), 32'd1);
        send_word(CMD_WRITE, low_addr(0),  32'd0);
        send_word(CMD_TICK,  6'h00,        32'h0);
        // zero period on channel 2
        send_word(CMD_WRITE, ctrl_addr(2), 32'h1);
        send_word(CMD_TICK,  6'h00,        32'h0);
        // unmapped offsets, unused command
        send_word(CMD_READ,  6'h02,        32'h0);
        send_word(CMD_WRITE, 6'h24,        32'hA5A5_5A5A);
        send_word(CMD_READ,  6'h24,        32'h0);
        send_word(CMD_READ,  6'h3C,        32'h0);
        send_word(CMD_NONE,  high_addr(0), 32'hFFFF_FFFF);
        // stop, then start again at the high phase
        send_word(CMD_WRITE, ctrl_addr(0), 32'h0);
        send_word(CMD_WRITE, ctrl_addr(0), 32'h1);
        send_word(CMD_TICK,  6'h00,        32'h0);

        // random traffic: mostly small periods so levels toggle often
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 150 && i < 300);
            if (i == 450)
            begin
                // hold off until every result has come back
                in_valid <= 1'b0;
                @(posedge clk);
                while (mirror.owed_results.size() != 0)
                    @(posedge clk);
            end
            roll  = $urandom_range(0, 99);
            pick  = $urandom_range(0, 99);
            chan  = $urandom_range(0, CHANNELS - 1);
            value = $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0)
                value = $urandom;
            else if ($urandom_range(0, 29) == 0)
                value = 32'hFFFF_FFFF;
            if (roll < 48)
                send_word(CMD_TICK, ADDR_W'($urandom), $urandom);
            else if (roll < 72)
            begin
                if (pick < 35)
                    send_word(CMD_WRITE, high_addr(chan), value);
                else if (pick < 70)
                    send_word(CMD_WRITE, low_addr(chan), value);
                else if (pick < 90)
                begin
                    value = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
                    value[CTRL_RUN_BIT]     = ($urandom_range(0, 9) != 0);
                    value[CTRL_RESTART_BIT] = 1'($urandom_range(0, 1));
                    send_word(CMD_WRITE, ctrl_addr(chan), value);
                end
                else
                    send_word(CMD_WRITE, ADDR_W'($urandom), $urandom);
            end
            else if (roll < 97)
            begin
                case ($urandom_range(0, 4))
                    0:       where = high_addr(chan);
                    1:       where = low_addr(chan);
                    2, 3:    where = ctrl_addr(chan);
                    default: where = ADDR_W'($urandom);
                endcase
                send_word(CMD_READ, where, $urandom);
            end
            else
                send_word(CMD_NONE, ADDR_W'($urandom), $urandom);
        end
        calm = 1'b0;

        // drop valid and let the pipeline empty
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mirror.mismatches == 0 && mirror.owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> three_channel_pwm_generator.f
rtl/tcpwm_pkg.sv
rtl/tcpwm_channel.sv
rtl/three_channel_pwm_generator.sv
rtl/tcpwm_checker.sv
test/tb.sv
